// ===== hw/rtl/glsf_pkg.sv =====
// Shared types, constants and helpers for the grid line smoothing filter.
package glsf_pkg;

  // Sample and window geometry
  localparam int SAMPLE_BITS = 32;
  localparam int NUM_TAPS    = 5;

  // Datapath widths: filter difference, blend product, delta before the final add
  localparam int T_W    = 39;
  localparam int PROD_W = 56;
  localparam int D_W    = 36;

  // Configuration register indexes
  localparam logic [1:0] REG_FILTER_KIND     = 2'd0;
  localparam logic [1:0] REG_BLEND_FACTOR    = 2'd1;
  localparam logic [1:0] REG_INTERIOR_LENGTH = 2'd2;

  // filter_kind codes that are not TSC
  localparam logic [2:0] KIND_FIVE_A = 3'd0;
  localparam logic [2:0] KIND_BINOM  = 3'd2;
  localparam logic [2:0] KIND_FIVE_B = 3'd3;

  // Internal filter modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_TSC   = 2'd0;
  localparam mode_t MODE_BINOM = 2'd1;
  localparam mode_t MODE_FIVE  = 2'd2;

  // Blend factor of one (16 fraction bits)
  localparam logic [16:0] BLEND_ONE = 17'd65536;

  // Rounding offsets: D*32768 folded into the shift for each denominator
  localparam logic signed [PROD_W-1:0] RND_BINOM = PROD_W'(64'd131072);   // 4*32768
  localparam logic signed [PROD_W-1:0] RND_TSC   = PROD_W'(64'd262144);   // 8*32768
  localparam logic signed [PROD_W-1:0] RND_FIVE  = PROD_W'(64'd3145728);  // 96*32768
  // Five-tap path: bias to make the value positive before dividing by 3
  localparam logic [D_W-1:0] FIVE_BIAS   = D_W'(64'd25769803776);        // 3 * 2^33
  localparam logic [D_W-1:0] FIVE_UNBIAS = D_W'(64'd8589934592);         // 2^33

  // ceil(2^24 / 3)
  localparam logic [22:0] DIV3_RECIP = 23'd5592406;

  typedef logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] window_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic  valid;
    logic  last;
    mode_t mode;
  } ctl_t;

  // Map register code to filter mode
  function automatic mode_t decode_mode(input logic [2:0] kind);
    mode_t m;
    case (kind)
      KIND_FIVE_A: m = MODE_FIVE;
      KIND_FIVE_B: m = MODE_FIVE;
      KIND_BINOM:  m = MODE_BINOM;
      default:     m = MODE_TSC;
    endcase
    return m;
  endfunction

  // floor(n / 3) by reciprocal multiply; exact for quotients below 2^18
  function automatic logic [17:0] div3(input logic [19:0] n);
    logic [42:0] p;
    p = {23'b0, n} * {20'b0, DIV3_RECIP};
    return p[41:24];
  endfunction

endpackage

// ===== hw/rtl/grid_line_smoothing_filter_unit.sv =====
// Grid line smoothing filter: tap cell chain, line position tracking and blend pipeline.
// Control for a result passes through s1_ctl to s6_ctl, then out_valid, after its interior sample is accepted.
// Throughput: one sample per cycle while no result is held; ghost samples produce no transaction.
// A held output (out_valid with out_stall) freezes the tap chain and all pipeline stages.
// Reset (rst, synchronous): taps clear to zero, line position to zero, pipeline empties,
// filter_kind = 1 (TSC), blend_factor = 0, interior_length = 1024.
module grid_line_smoothing_filter_unit #(
  parameter int MAX_CELLS    = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [1:0]                              cfg_index,
  input  logic [16:0]                             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [glsf_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                    first_of_line,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [glsf_pkg::SAMPLE_BITS-1:0] smoothed_out,
  output logic                                    last_of_line
);
  import glsf_pkg::*;

  localparam int PW = $clog2(MAX_CELLS + 6);
  localparam logic [PW-1:0] POS_CAP = PW'(MAX_CELLS + 5);

  // Configuration registers
  logic [2:0]  filter_kind;
  logic [16:0] blend_factor;
  logic [10:0] interior_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind     <= 3'd1;
      blend_factor    <= '0;
      interior_length <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_KIND:     filter_kind     <= cfg_data[2:0];
        REG_BLEND_FACTOR:    blend_factor    <= cfg_data;
        REG_INTERIOR_LENGTH: interior_length <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: only a held output result blocks
  logic adv, accept;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Tap window: chain of cells, newest sample in cell 0
  window_t taps;
  genvar gi;
  generate
    for (gi = 0; gi < NUM_TAPS; gi++) begin : g_tap
      if (gi == 0) begin : g_head
        glsf_tap_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (accept),
          .d        (sample_in),
          .q        (taps[gi])
        );
      end else begin : g_body
        glsf_tap_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (accept),
          .d        (taps[gi-1]),
          .q        (taps[gi])
        );
      end
    end
  endgenerate

  // Line position, saturating at the cap
  logic [PW-1:0] pos, pos_next;
  always_comb begin
    if (first_of_line) begin
      pos_next = PW'(1);
    end else if (pos < POS_CAP) begin
      pos_next = pos + PW'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Interior window test for the incoming sample
  mode_t       mode;
  logic [31:0] len_w, first_w, last_w, pos_w;
  logic        emit;
  always_comb begin
    mode    = decode_mode(filter_kind);
    len_w   = (32'(interior_length) > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : 32'(interior_length);
    first_w = (mode == MODE_FIVE) ? 32'd5 : 32'd3;
    last_w  = len_w + ((mode == MODE_FIVE) ? 32'd4 : 32'd2);
    pos_w   = 32'(pos_next);
    emit    = (len_w != 32'd0) && (pos_w >= first_w) && (pos_w <= last_w);
  end

  ctl_t ctl_in;
  always_comb begin
    ctl_in.valid = in_valid && emit;
    ctl_in.last  = (pos_w == last_w);
    ctl_in.mode  = mode;
  end

  glsf_blend_pipe #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .ctl_in       (ctl_in),
    .window       (taps),
    .blend_factor (blend_factor),
    .out_valid    (out_valid),
    .smoothed_out (smoothed_out),
    .last_of_line (last_of_line)
  );

  // Assertions
  a_pos_capped: assert property (@(posedge clk) disable iff (rst) pos <= POS_CAP)
    else $error("line position beyond cap");

  a_held_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && first_of_line) |=> (pos == PW'(1)))
    else $error("line position not restarted");

endmodule

// ===== hw/rtl/glsf_tap_cell.sv =====
// One cell of the tap window: holds a sample and hands it to the next cell.
module glsf_tap_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift_en,
  input  logic [glsf_pkg::SAMPLE_BITS-1:0]    d,
  output logic [glsf_pkg::SAMPLE_BITS-1:0]    q
);
  import glsf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift_en) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/glsf_blend_pipe.sv =====
// Filter, blend, round and saturate pipeline fed from the tap window.
module glsf_blend_pipe #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  glsf_pkg::ctl_t                       ctl_in,
  input  glsf_pkg::window_t                    window,
  input  logic [16:0]                          blend_factor,
  output logic                                 out_valid,
  output logic signed [glsf_pkg::SAMPLE_BITS-1:0] smoothed_out,
  output logic                                 last_of_line
);
  import glsf_pkg::*;

  // Saturation bounds at the internal width
  localparam int SW_EFF = (SAMPLE_WIDTH < D_W) ? SAMPLE_WIDTH : D_W;
  localparam logic [D_W-1:0] ONE_D = {{(D_W-1){1'b0}}, 1'b1};
  localparam logic [D_W-1:0] SAT_HI = (ONE_D << (SW_EFF - 1)) - ONE_D;
  localparam logic [D_W-1:0] SAT_LO = ~SAT_HI;

  // Pipeline registers
  ctl_t s1_ctl, s2_ctl, s3_ctl, s4_ctl, s5_ctl, s6_ctl;
  logic signed [SAMPLE_BITS-1:0] s2_x, s3_x, s4_x, s5_x, s6_x;
  logic signed [T_W-1:0]         s2_t;
  logic signed [PROD_W-1:0]      s3_prod;
  logic [D_W-1:0]                s4_v, s5_v;
  logic [17:0]                   s5_qh;
  logic [19:0]                   s5_n2;
  logic [D_W-1:0]                s6_d;

  // Stage A: center sample and filter difference S - D*x
  logic signed [T_W-1:0] tw0, tw1, tw2, tw3, tw4;
  logic signed [T_W-1:0] t_a, a_sum, b_sum;
  logic signed [SAMPLE_BITS-1:0] x_a;

  always_comb begin
    tw0 = {{(T_W-SAMPLE_BITS){window[0][SAMPLE_BITS-1]}}, window[0]};
    tw1 = {{(T_W-SAMPLE_BITS){window[1][SAMPLE_BITS-1]}}, window[1]};
    tw2 = {{(T_W-SAMPLE_BITS){window[2][SAMPLE_BITS-1]}}, window[2]};
    tw3 = {{(T_W-SAMPLE_BITS){window[3][SAMPLE_BITS-1]}}, window[3]};
    tw4 = {{(T_W-SAMPLE_BITS){window[4][SAMPLE_BITS-1]}}, window[4]};
    a_sum = tw1 + tw3;
    b_sum = tw0 + tw4;
    if (s1_ctl.mode == MODE_FIVE) begin
      x_a = window[2];
      // 24*(w1+w3) + (w0+w4) - 50*x
      t_a = (a_sum <<< 4) + (a_sum <<< 3) + b_sum - (tw2 <<< 5) - (tw2 <<< 4) - (tw2 <<< 1);
    end else begin
      x_a = window[1];
      t_a = tw0 + tw2 - (tw1 <<< 1);
    end
  end

  // Stage B: blend factor times difference
  logic [16:0]               b_eff;
  logic signed [T_W+17:0]    prod_full;

  always_comb begin
    b_eff = (blend_factor > BLEND_ONE) ? BLEND_ONE : blend_factor;
    prod_full = $signed({1'b0, b_eff}) * s2_t;
  end

  // Stage C: round and scale by the denominator (five-tap leaves a divide by 3)
  logic signed [PROD_W-1:0] sum_five, sum_bin, sum_tsc;
  logic signed [34:0]       m2;
  logic [D_W-1:0]           v_c;

  always_comb begin
    sum_five = s3_prod + RND_FIVE;
    sum_bin  = s3_prod + RND_BINOM;
    sum_tsc  = s3_prod + RND_TSC;
    m2 = sum_five[PROD_W-1:21];
    case (s3_ctl.mode)
      MODE_FIVE:  v_c = {m2[34], m2} + FIVE_BIAS;
      MODE_BINOM: v_c = sum_bin[D_W+17:18];
      default:    v_c = sum_tsc[D_W+18:19];
    endcase
  end

  // Stage D: divide upper half by 3, carry the remainder down
  logic [17:0] vh, qh_d, r_full;
  always_comb begin
    vh = s4_v[D_W-1:18];
    qh_d = div3({2'b0, vh});
    r_full = vh - ({qh_d[16:0], 1'b0} + qh_d);
  end

  // Stage E: divide lower part, remove bias
  logic [17:0]    q2;
  logic [D_W-1:0] q_full;
  always_comb begin
    q2 = div3(s5_n2);
    q_full = {s5_qh, 18'b0} + {18'b0, q2};
  end

  // Stage F: add to center sample and saturate
  logic signed [D_W-1:0] y_f;
  logic signed [D_W-1:0] y_sat;
  always_comb begin
    y_f = {{(D_W-SAMPLE_BITS){s6_x[SAMPLE_BITS-1]}}, s6_x} + $signed(s6_d);
    if (y_f > $signed(SAT_HI)) begin
      y_sat = $signed(SAT_HI);
    end else if (y_f < $signed(SAT_LO)) begin
      y_sat = $signed(SAT_LO);
    end else begin
      y_sat = y_f;
    end
  end

  // Control: valid bits reset, everything moves together on adv
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl    <= '0;
      s2_ctl    <= '0;
      s3_ctl    <= '0;
      s4_ctl    <= '0;
      s5_ctl    <= '0;
      s6_ctl    <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_ctl    <= ctl_in;
      s2_ctl    <= s1_ctl;
      s3_ctl    <= s2_ctl;
      s4_ctl    <= s3_ctl;
      s5_ctl    <= s4_ctl;
      s6_ctl    <= s5_ctl;
      out_valid <= s6_ctl.valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x         <= x_a;
      s2_t         <= t_a;
      s3_x         <= s2_x;
      s3_prod      <= prod_full[PROD_W-1:0];
      s4_x         <= s3_x;
      s4_v         <= v_c;
      s5_x         <= s4_x;
      s5_v         <= s4_v;
      s5_qh        <= qh_d;
      s5_n2        <= {r_full[1:0], s4_v[17:0]};
      s6_x         <= s5_x;
      s6_d         <= (s5_ctl.mode == MODE_FIVE) ? (q_full - FIVE_UNBIAS) : s5_v;
      smoothed_out <= y_sat[SAMPLE_BITS-1:0];
      last_of_line <= s6_ctl.last;
    end
  end

endmodule
